/* hw/rtl/asp_pkg.sv */
package asp_pkg;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_RESIZE = 2'd1;
  localparam logic [1:0] CMD_FREE = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  localparam int SIZE_W = 32;
  localparam int BIN_W = 32;
  localparam int IDX_IN_W = 12;
  localparam int EVT_W = 40;
  localparam int MEAN_W = 48;
  localparam int LIVE_W = 32;
  localparam int PEAK_W = 31;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    logic [1:0] cmd;
    logic [SIZE_W-1:0] size;
    logic [IDX_IN_W-1:0] bin_index;
    logic ign;
  } asp_cmd_t;

endpackage

/* hw/rtl/asp_ram.sv */
module asp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/asp_front.sv */
module asp_front import asp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] in_command,
  input  logic [SIZE_W-1:0] in_size,
  input  logic [IDX_IN_W-1:0] in_bin_index,
  output logic q_valid,
  input  logic q_pop,
  output asp_cmd_t q_data
);
  // two-entry queue
  asp_cmd_t ent_r [2];
  logic [1:0] cnt_r;
  logic rd_r, wr_r;
  logic push;
  asp_cmd_t cls;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = ent_r[rd_r];

  always_comb begin
    cls.cmd = in_command;
    cls.size = in_size;
    cls.bin_index = in_bin_index;
    cls.ign = (in_command == CMD_ALLOC || in_command == CMD_RESIZE) && (in_size == '0);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= cls;
    end
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (q_pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> in_stall) else $error("full queue not stalling");
`endif
endmodule

/* hw/rtl/asp_back.sv */
module asp_back import asp_pkg::*; #(
  parameter int BIN_COUNT = 4096,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_pop,
  input  asp_cmd_t q_data,
  output logic out_valid,
  input  logic out_stall,
  output logic [BIN_W-1:0] out_bin_value,
  output logic [EVT_W-1:0] out_event_count,
  output logic [MEAN_W-1:0] out_mean_size,
  output logic signed [LIVE_W-1:0] out_live_count,
  output logic [PEAK_W-1:0] out_peak_live,
  output logic out_ignored
);
  localparam int AW = $clog2(BIN_COUNT);
  // dividend magnitude width: scaled size or mean, whichever is wider, plus one
  localparam int DW = ((SIZE_W + FRACTION_BITS > MEAN_W) ? SIZE_W + FRACTION_BITS
                                                         : MEAN_W) + 1;
  localparam int QW = 6;                   // divider step counter
  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_RD = 3'd2, S_DIV = 3'd3,
                         S_WR = 3'd4, S_OUT = 3'd5;

  logic [2:0] st_r;
  logic [AW-1:0] clr_r;
  asp_cmd_t c_r;
  logic [AW-1:0] slot_r;
  logic [EVT_W-1:0] evt_r;
  logic [MEAN_W-1:0] mean_r;
  logic signed [LIVE_W-1:0] live_r;
  logic [PEAK_W-1:0] peak_r;

  logic [DW-1:0] rem_r, quo_r, mag_r;
  logic [EVT_W:0] dvs_r;
  logic neg_r;
  logic [QW-1:0] step_r;
  logic [BIN_W-1:0] bin_r;

  logic ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [BIN_W-1:0] ram_wd, ram_rd;

  asp_ram #(.WIDTH(BIN_W), .DEPTH(BIN_COUNT)) u_bins (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
    .raddr(ram_ra), .rdata(ram_rd)
  );

  logic [DW-1:0] target;
  logic [AW-1:0] slot_c;
  logic [DW-1:0] rem_sh;
  logic [DW:0] trial;
  logic [MEAN_W-1:0] nm;
  logic bin_ok;

  assign target = DW'(q_data.size) << FRACTION_BITS;
  assign slot_c = (q_data.size >= SIZE_W'(BIN_COUNT)) ? AW'(BIN_COUNT - 1)
                                                    : AW'(q_data.size - 1);
  assign ram_ra = (q_data.cmd == CMD_READ) ? AW'(q_data.bin_index) : slot_c;
  assign ram_we = (st_r == S_CLR) || (st_r == S_WR);
  assign ram_wa = (st_r == S_CLR) ? clr_r : slot_r;
  assign ram_wd = (st_r == S_CLR) ? '0 : bin_r;
  assign q_pop = (st_r == S_IDLE) && q_valid;
  // every index is a bin when the store covers the whole index range
  assign bin_ok = (BIN_COUNT >= (1 << IDX_IN_W)) ||
                  (c_r.bin_index < IDX_IN_W'(BIN_COUNT));

  // restoring divide, one quotient bit a cycle
  assign rem_sh = {rem_r[DW-2:0], mag_r[DW-1]};
  assign trial = {1'b0, rem_sh} - {{(DW-EVT_W){1'b0}}, dvs_r};
  always_comb begin
    logic [DW:0] s;
    s = neg_r ? ((DW+1)'(mean_r) - (DW+1)'(quo_r))
              : ((DW+1)'(mean_r) + (DW+1)'(quo_r));
    nm = (s > (DW+1)'({MEAN_W{1'b1}})) ? '1 : s[MEAN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      clr_r <= '0;
      out_valid <= 1'b0;
      evt_r <= '0;
      mean_r <= '0;
      live_r <= '0;
      peak_r <= '0;
    end else begin
      unique case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(BIN_COUNT - 1)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            c_r <= q_data;
            slot_r <= slot_c;
            neg_r <= target < DW'(mean_r);
            mag_r <= (target >= DW'(mean_r)) ? target - DW'(mean_r)
                                             : DW'(mean_r) - target;
            dvs_r <= {1'b0, evt_r} + 1'b1;
            rem_r <= '0;
            quo_r <= '0;
            step_r <= '0;
            st_r <= S_RD;
          end
        end
        S_RD: begin
          // bin read data now valid
          out_ignored <= c_r.ign;
          if (c_r.cmd == CMD_READ) begin
            out_bin_value <= bin_ok ? ram_rd : '0;
            st_r <= S_OUT;
          end else if (c_r.cmd == CMD_FREE) begin
            out_bin_value <= '0;
            if (live_r != {1'b1, {(LIVE_W-1){1'b0}}}) live_r <= live_r - 1'b1;
            st_r <= S_OUT;
          end else if (c_r.ign) begin
            out_bin_value <= '0;
            st_r <= S_OUT;
          end else begin
            bin_r <= (ram_rd == '1) ? ram_rd : ram_rd + 1'b1;
            st_r <= S_DIV;
          end
        end
        S_DIV: begin
          mag_r <= {mag_r[DW-2:0], 1'b0};
          if (!trial[DW]) begin
            rem_r <= trial[DW-1:0];
            quo_r <= {quo_r[DW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[DW-2:0], 1'b0};
          end
          step_r <= step_r + 1'b1;
          if (step_r == QW'(DW - 1)) st_r <= S_WR;
        end
        S_WR: begin
          mean_r <= nm;
          if (evt_r != '1) evt_r <= evt_r + 1'b1;
          out_bin_value <= bin_r;
          if (c_r.cmd == CMD_ALLOC && live_r != {1'b0, {(LIVE_W-1){1'b1}}}) begin
            live_r <= live_r + 1'b1;
            if (!live_r[LIVE_W-1] && (live_r[PEAK_W-1:0] + 1'b1) > peak_r)
              peak_r <= live_r[PEAK_W-1:0] + 1'b1;
          end
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
            st_r <= S_IDLE;
          end else begin
            out_valid <= 1'b1;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_event_count = evt_r;
  assign out_mean_size = mean_r;
  assign out_live_count = live_r;
  assign out_peak_live = peak_r;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> st_r == S_RD) else $error("pop without start");
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> st_r == S_OUT) else $error("result outside output state");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_bin_value) &&
    $stable(out_event_count) && $stable(out_mean_size) && $stable(out_live_count) &&
    $stable(out_peak_live) && $stable(out_ignored)))
    else $error("stalled result changed");
  a_no_write_rd: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (st_r == S_CLR || st_r == S_WR)) else $error("stray bin write");
`endif
endmodule

/* hw/rtl/allocation_size_profiler.sv */
// Sequence: an allocation or resize passes through queue hand-off, bin read,
// 49 divider steps, write-back and output before out_valid rises; a free, bin
// read or zero size skips the divider and write-back; output stalls delay it.
// Throughput: one word at a time through the back end, which takes the next word
// only once the last result has left; the 49-step restoring divider sets the pace.
// Reset: rst_n synchronous; afterwards the histogram RAM is swept to zero,
// one bin a cycle, while queued words wait.
module allocation_size_profiler import asp_pkg::*; #(
  parameter int BIN_COUNT = 4096,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] in_command,
  input  logic [SIZE_W-1:0] in_size,
  input  logic [IDX_IN_W-1:0] in_bin_index,
  output logic out_valid,
  input  logic out_stall,
  output logic [BIN_W-1:0] out_bin_value,
  output logic [EVT_W-1:0] out_event_count,
  output logic [MEAN_W-1:0] out_mean_size,
  output logic signed [LIVE_W-1:0] out_live_count,
  output logic [PEAK_W-1:0] out_peak_live,
  output logic out_ignored
);
  // front end classifies words into a two-deep queue
  logic q_valid, q_pop;
  asp_cmd_t q_data;

  asp_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .in_size, .in_bin_index,
    .q_valid, .q_pop, .q_data
  );

  // back end: histogram RAM, mean divider, counters
  asp_back #(.BIN_COUNT(BIN_COUNT), .FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_data, .out_valid, .out_stall,
    .out_bin_value, .out_event_count, .out_mean_size, .out_live_count,
    .out_peak_live, .out_ignored
  );
endmodule
